[design/prg_pkg.sv]
// Shared types and constants for the primary ray generator.
// No dependencies; the front, norm, sqrt, div and top-level design files import it.
package prg_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    localparam int CFG_W = 48;
    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_CAM_POSITION  = 3'd0;
    localparam logic [IDX_W-1:0] REG_BASIS_FORWARD = 3'd1;
    localparam logic [IDX_W-1:0] REG_BASIS_RIGHT   = 3'd2;
    localparam logic [IDX_W-1:0] REG_BASIS_UP      = 3'd3;
    localparam logic [IDX_W-1:0] REG_FOCAL_LENGTH  = 3'd4;
    localparam logic [IDX_W-1:0] REG_FOV_SCALE     = 3'd5;
    localparam logic [IDX_W-1:0] REG_INV_ASPECT    = 3'd6;

    localparam logic [47:0] RST_CAM_POSITION  = 48'h0000_0000_0000;
    localparam logic [47:0] RST_BASIS_FORWARD = 48'h0000_0000_4000;
    localparam logic [47:0] RST_BASIS_RIGHT   = 48'h0000_0000_0000;
    localparam logic [47:0] RST_BASIS_UP      = 48'h0000_4000_0000;
    localparam logic [15:0] RST_FOCAL_LENGTH  = 16'h0100;
    localparam logic [15:0] RST_FOV_SCALE     = 16'h1000;
    localparam logic [15:0] RST_INV_ASPECT    = 16'h1000;

    // offset magnitude, normalized magnitude, sum of squares, length
    localparam int MAG_W = 42;
    localparam int NRM_W = 30;
    localparam int SUM_W = 62;
    localparam int LEN_W = 31;

    localparam logic [14:0] DIR_ONE = 15'h4000;

    typedef struct packed {
        logic [47:0] pos;
        logic [47:0] fwd;
        logic [47:0] right;
        logic [47:0] up;
        logic [15:0] focal;
        logic [15:0] fov;
        logic [15:0] inv_aspect;
    } cam_cfg_t;

    typedef struct packed {
        logic [2:0][15:0]      origin;
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
    } front_item_t;

    typedef struct packed {
        logic [2:0][15:0]      origin;
        logic [2:0]            neg;
        logic                  zero;
        logic [2:0][NRM_W-1:0] mag;
    } norm_item_t;

    typedef struct packed {
        logic [2:0][15:0] origin;
        logic [2:0][15:0] dir;
        logic             zero;
    } ray_item_t;

endpackage

[design/prg_ifs.sv]
// Handshake channels of the primary ray generator: screen coordinates in,
// rays out. No dependencies.
interface prg_screen_if;
    logic        valid;
    logic        ready;
    logic [15:0] screen_u;
    logic [15:0] screen_v;

    modport source (output valid, output screen_u, output screen_v, input ready);
    modport sink (input valid, input screen_u, input screen_v, output ready);
endinterface

interface prg_ray_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic               zero_length;

    modport source (output valid, output origin_x, output origin_y, output origin_z,
                    output dir_x, output dir_y, output dir_z, output zero_length,
                    input ready);
    modport sink (input valid, input origin_x, input origin_y, input origin_z,
                  input dir_x, input dir_y, input dir_z, input zero_length,
                  output ready);
endinterface

[design/prg_front.sv]
// Front stages: screen scale, H and V offsets, basis products, offset sum,
// saturated origin and offset magnitudes. Depends on prg_pkg.
module prg_front #(
    parameter int COORD_WIDTH = prg_pkg::COORD_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  prg_pkg::cam_cfg_t    cfg,
    input  logic                 in_valid,
    input  logic [15:0]          in_u,
    input  logic [15:0]          in_v,
    output logic                 out_valid,
    output prg_pkg::front_item_t out_item
);
    import prg_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam logic [DW-1:0] HALF = DW'(1) << (COORD_WIDTH - 1);

    logic [5:0] vld_reg;

    // stage 1
    logic [COORD_WIDTH-1:0] u_eff;
    logic [COORD_WIDTH-1:0] v_eff;
    logic [31:0]            s_prod;
    logic signed [DW-1:0]   du1_next;
    logic signed [DW-1:0]   dv1_next;
    logic signed [DW-1:0]   du1_reg;
    logic signed [DW-1:0]   dv1_reg;
    logic [19:0]            s1_reg;

    // stage 2
    logic [35:0]            sv_prod;
    logic signed [DW+20:0]  h_prod;
    logic signed [DW-1:0]   dv2_reg;
    logic [23:0]            sv2_reg;
    logic signed [20:0]     h2_reg;

    // stage 3
    logic signed [DW+24:0]  v_prod;
    logic signed [20:0]     h3_reg;
    logic signed [24:0]     v3_reg;

    // stages 4 to 6
    logic signed [32:0]     pf_reg [3];
    logic signed [36:0]     ph_reg [3];
    logic signed [40:0]     pv_reg [3];
    logic signed [42:0]     off_reg [3];
    front_item_t            item_next;
    front_item_t            item_reg;

    assign u_eff    = COORD_WIDTH'(in_u);
    assign v_eff    = COORD_WIDTH'(in_v);
    assign du1_next = $signed({1'b0, u_eff} - HALF);
    assign dv1_next = $signed({1'b0, v_eff} - HALF);
    assign s_prod   = 32'(cfg.focal) * 32'(cfg.fov);

    assign sv_prod  = 36'(s1_reg) * 36'(cfg.inv_aspect);
    assign h_prod   = (DW+21)'(du1_reg) * (DW+21)'($signed({1'b0, s1_reg}));
    assign v_prod   = (DW+25)'(dv2_reg) * (DW+25)'($signed({1'b0, sv2_reg}));

    always_comb
    begin
        logic signed [29:0] osum;
        logic [42:0]        mag;
        item_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            osum = 30'($signed(cfg.pos[16*i +: 16])) + 30'(off_reg[i] >>> 14);
            if (osum > 30'sd32767)
            begin
                item_next.origin[i] = 16'h7FFF;
            end
            else if (osum < -30'sd32768)
            begin
                item_next.origin[i] = 16'h8000;
            end
            else
            begin
                item_next.origin[i] = osum[15:0];
            end
            mag = off_reg[i][42] ? 43'(-off_reg[i]) : 43'(off_reg[i]);
            item_next.neg[i] = off_reg[i][42];
            item_next.mag[i] = MAG_W'(mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            du1_reg <= du1_next;
            dv1_reg <= dv1_next;
            s1_reg  <= s_prod[31:12];
            dv2_reg <= dv1_reg;
            sv2_reg <= sv_prod[35:12];
            h2_reg  <= 21'(h_prod >>> COORD_WIDTH);
            h3_reg  <= h2_reg;
            v3_reg  <= 25'(v_prod >>> COORD_WIDTH);
            for (int i = 0; i < 3; i++)
            begin
                pf_reg[i]  <= 33'($signed({1'b0, cfg.focal})) * 33'($signed(cfg.fwd[16*i +: 16]));
                ph_reg[i]  <= 37'(h3_reg) * 37'($signed(cfg.right[16*i +: 16]));
                pv_reg[i]  <= 41'(v3_reg) * 41'($signed(cfg.up[16*i +: 16]));
                off_reg[i] <= 43'(pf_reg[i]) + 43'(ph_reg[i]) - 43'(pv_reg[i]);
            end
            item_reg <= item_next;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_item  = item_reg;

endmodule

[design/prg_norm.sv]
// Normalizing stages: leading-one search over the offset magnitudes,
// common shift into [2^29, 2^30), squares and their sum. Depends on prg_pkg.
module prg_norm (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  prg_pkg::front_item_t in_item,
    output logic                 out_valid,
    output prg_pkg::norm_item_t  out_item,
    output logic [prg_pkg::SUM_W-1:0] out_sum
);
    import prg_pkg::*;

    localparam int GROUPS = 6;
    localparam int EXT_W  = MAG_W + NRM_W - 1;

    logic [5:0]           vld_reg;
    logic [47:0]          or_pad;
    logic [GROUPS-1:0]    gnz_next;
    logic [2:0]           gpos_next [GROUPS];
    logic [GROUPS-1:0]    gnz_reg;
    logic [2:0]           gpos_reg [GROUPS];
    front_item_t          it1_reg;
    logic [5:0]           pos_next;
    logic [5:0]           pos_reg;
    logic                 zero2_reg;
    front_item_t          it2_reg;
    logic [EXT_W-1:0]     ext_reg [3];
    logic [2:0]           fine_reg;
    logic                 zero3_reg;
    front_item_t          it3_reg;
    norm_item_t           it4_reg;
    logic [2*NRM_W-1:0]   sq_reg [3];
    norm_item_t           it5_reg;
    norm_item_t           it6_reg;
    logic [SUM_W-1:0]     sum_reg;

    assign or_pad = 48'(in_item.mag[0] | in_item.mag[1] | in_item.mag[2]);

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            gnz_next[g]  = |or_pad[8*g +: 8];
            gpos_next[g] = '0;
            for (int b = 0; b < 8; b++)
            begin
                if (or_pad[8*g + b])
                begin
                    gpos_next[g] = 3'(b);
                end
            end
        end
    end

    always_comb
    begin
        pos_next = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            if (gnz_reg[g])
            begin
                pos_next = {3'(g), gpos_reg[g]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gnz_reg  <= gnz_next;
            gpos_reg <= gpos_next;
            it1_reg  <= in_item;

            pos_reg   <= pos_next;
            zero2_reg <= ~|gnz_reg;
            it2_reg   <= it1_reg;

            // scale every magnitude by 2^(29 - pos): coarse byte shift first
            for (int i = 0; i < 3; i++)
            begin
                ext_reg[i] <= {it2_reg.mag[i], (NRM_W-1)'(0)} >> {pos_reg[5:3], 3'b000};
            end
            fine_reg  <= pos_reg[2:0];
            zero3_reg <= zero2_reg;
            it3_reg   <= it2_reg;

            it4_reg.origin <= it3_reg.origin;
            it4_reg.neg    <= it3_reg.neg;
            it4_reg.zero   <= zero3_reg;
            for (int i = 0; i < 3; i++)
            begin
                it4_reg.mag[i] <= NRM_W'(ext_reg[i] >> fine_reg);
            end

            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= (2*NRM_W)'(it4_reg.mag[i]) * (2*NRM_W)'(it4_reg.mag[i]);
            end
            it5_reg <= it4_reg;

            sum_reg <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            it6_reg <= it5_reg;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_item  = it6_reg;
    assign out_sum   = sum_reg;

endmodule

[design/prg_sqrt.sv]
// Pipelined integer square root, one result bit per stage, with the ray
// sideband carried alongside. Depends on prg_pkg.
module prg_sqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [prg_pkg::SUM_W-1:0] in_sum,
    input  prg_pkg::norm_item_t       in_item,
    output logic                      out_valid,
    output logic [prg_pkg::LEN_W-1:0] out_root,
    output prg_pkg::norm_item_t       out_item
);
    import prg_pkg::*;

    localparam int STEPS = SUM_W / 2;
    localparam int REM_W = LEN_W + 2;

    logic [STEPS-1:0] vld_reg;
    logic [REM_W-1:0] rem_reg  [STEPS];
    logic [LEN_W-1:0] root_reg [STEPS];
    logic [SUM_W-1:0] x_reg    [STEPS];
    norm_item_t       item_reg [STEPS];

    for (genvar s = 0; s < STEPS; s++)
    begin : g_step
        logic [REM_W-1:0] rem_in;
        logic [LEN_W-1:0] root_in;
        logic [SUM_W-1:0] x_in;
        norm_item_t       item_in;
        logic             vld_in;
        logic [REM_W-1:0] r2;
        logic [REM_W-1:0] trial;
        logic             take;

        if (s == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = in_sum;
            assign item_in = in_item;
            assign vld_in  = in_valid;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign x_in    = x_reg[s-1];
            assign item_in = item_reg[s-1];
            assign vld_in  = vld_reg[s-1];
        end

        // bring down the next two bits and try root*4 + 1
        assign r2    = {rem_in[REM_W-3:0], x_in[SUM_W-1 -: 2]};
        assign trial = {root_in, 2'b01};
        assign take  = (r2 >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= take ? r2 - trial : r2;
                root_reg[s] <= {root_in[LEN_W-2:0], take};
                x_reg[s]    <= x_in << 2;
                item_reg[s] <= item_in;
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign out_root  = root_reg[STEPS-1];
    assign out_item  = item_reg[STEPS-1];

endmodule

[design/prg_div.sv]
// Pipelined restoring divider, three lanes sharing one divisor: rounds
// |c|*2^14 / L to the nearest, clamps to 2^14 and applies the sign. Depends on prg_pkg.
module prg_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [prg_pkg::LEN_W-1:0] in_len,
    input  prg_pkg::norm_item_t       in_item,
    output logic                      out_valid,
    output prg_pkg::ray_item_t        out_item
);
    import prg_pkg::*;

    localparam int QBITS = 15;
    localparam int NUM_W = NRM_W + 15;
    localparam int REM_W = NUM_W + 1;

    typedef struct packed {
        logic [2:0][15:0] origin;
        logic [2:0]       neg;
        logic             zero;
    } div_side_t;

    logic [QBITS:0]   vld_reg;
    logic [REM_W-1:0] rem_reg  [QBITS+1][3];
    logic [QBITS-1:0] q_reg    [QBITS+1][3];
    logic [LEN_W-1:0] len_reg  [QBITS+1];
    div_side_t        side_reg [QBITS+1];
    ray_item_t        out_reg;
    logic             out_vld_reg;
    ray_item_t        out_next;

    // numerator with the rounding half of the divisor folded in
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= REM_W'({in_item.mag[i], 14'b0}) + REM_W'(in_len >> 1);
                q_reg[0][i]   <= '0;
            end
            len_reg[0]         <= in_len;
            side_reg[0].origin <= in_item.origin;
            side_reg[0].neg    <= in_item.neg;
            side_reg[0].zero   <= in_item.zero;
        end
    end

    for (genvar j = 1; j <= QBITS; j++)
    begin : g_step
        localparam int K = QBITS - j;
        logic [REM_W-1:0] trial;

        assign trial = REM_W'(len_reg[j-1]) << K;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_reg[j-1][i] >= trial)
                    begin
                        rem_reg[j][i] <= rem_reg[j-1][i] - trial;
                        q_reg[j][i]   <= q_reg[j-1][i] | (QBITS'(1) << K);
                    end
                    else
                    begin
                        rem_reg[j][i] <= rem_reg[j-1][i];
                        q_reg[j][i]   <= q_reg[j-1][i];
                    end
                end
                len_reg[j]  <= len_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    always_comb
    begin
        logic [QBITS-1:0] d;
        out_next.origin = side_reg[QBITS].origin;
        out_next.zero   = side_reg[QBITS].zero;
        for (int i = 0; i < 3; i++)
        begin
            d = (q_reg[QBITS][i] > DIR_ONE) ? DIR_ONE : q_reg[QBITS][i];
            if (side_reg[QBITS].zero)
            begin
                out_next.dir[i] = '0;
            end
            else if (side_reg[QBITS].neg[i])
            begin
                out_next.dir[i] = -16'(d);
            end
            else
            begin
                out_next.dir[i] = 16'(d);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[QBITS-1:0], in_valid};
            out_vld_reg <= vld_reg[QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_item  = out_reg;

endmodule

[design/primary_ray_generator.sv]
// Pinhole camera primary ray generator: top level with configuration
// registers and output queue. Depends on prg_pkg, prg_ifs and the prg_* stages.
//
// Usage:
//   screen carries one pair of normalized coordinates (u, v) per item; ray
//   returns one item per input with the focal-plane origin, the unit
//   direction and the zero_length flag. Items come out in input order.
//   Camera registers are written through cfg_we / cfg_index / cfg_data while
//   no item is in flight; indexes past the last register are ignored.
// Timing:
//   One item per cycle sustained while ray.ready is high. An item passes 61
//   register stages: 6 front stages, 6 normalizing stages, 31 square root
//   stages (one root bit each), 17 divider stages and the output queue.
// Reset:
//   rst_n clears all valid bits and the queue and loads the default camera:
//   origin at zero, forward +x, up +y, unit focal length, scale and aspect.
// Stall:
//   A two-entry output queue holds results while ray.ready is low. The whole
//   pipeline freezes only when its last stage holds an item and the queue is
//   full; screen.ready drops in those cycles and nothing is lost or repeated.
module primary_ray_generator #(
    parameter int COORD_WIDTH = prg_pkg::COORD_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [prg_pkg::IDX_W-1:0] cfg_index,
    input  logic [prg_pkg::CFG_W-1:0] cfg_data,
    prg_screen_if.sink                screen,
    prg_ray_if.source                 ray
);
    import prg_pkg::*;

    cam_cfg_t    cfg_reg;
    logic        en;

    logic        front_valid;
    front_item_t front_item;
    logic        norm_valid;
    norm_item_t  norm_item;
    logic [SUM_W-1:0] norm_sum;
    logic        sqrt_valid;
    logic [LEN_W-1:0] sqrt_root;
    norm_item_t  sqrt_item;
    logic        div_valid;
    ray_item_t   div_item;

    ray_item_t   q_mem [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        q_full;
    logic        push;
    logic        pop;
    ray_item_t   q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos        <= RST_CAM_POSITION;
            cfg_reg.fwd        <= RST_BASIS_FORWARD;
            cfg_reg.right      <= RST_BASIS_RIGHT;
            cfg_reg.up         <= RST_BASIS_UP;
            cfg_reg.focal      <= RST_FOCAL_LENGTH;
            cfg_reg.fov        <= RST_FOV_SCALE;
            cfg_reg.inv_aspect <= RST_INV_ASPECT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CAM_POSITION:  cfg_reg.pos        <= cfg_data;
                REG_BASIS_FORWARD: cfg_reg.fwd        <= cfg_data;
                REG_BASIS_RIGHT:   cfg_reg.right      <= cfg_data;
                REG_BASIS_UP:      cfg_reg.up         <= cfg_data;
                REG_FOCAL_LENGTH:  cfg_reg.focal      <= cfg_data[15:0];
                REG_FOV_SCALE:     cfg_reg.fov        <= cfg_data[15:0];
                REG_INV_ASPECT:    cfg_reg.inv_aspect <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    // freeze only when the last stage cannot drain into the queue
    assign q_full       = (count_reg == 2'd2);
    assign en           = !(div_valid && q_full);
    assign screen.ready = en;

    prg_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (screen.valid),
        .in_u      (screen.screen_u),
        .in_v      (screen.screen_v),
        .out_valid (front_valid),
        .out_item  (front_item)
    );

    prg_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_item   (front_item),
        .out_valid (norm_valid),
        .out_item  (norm_item),
        .out_sum   (norm_sum)
    );

    prg_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (norm_valid),
        .in_sum    (norm_sum),
        .in_item   (norm_item),
        .out_valid (sqrt_valid),
        .out_root  (sqrt_root),
        .out_item  (sqrt_item)
    );

    prg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sqrt_valid),
        .in_len    (sqrt_root),
        .in_item   (sqrt_item),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    assign push = div_valid && !q_full;
    assign pop  = ray.valid && ray.ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= div_item;
        end
    end

    assign q_head          = q_mem[rd_ptr_reg];
    assign ray.valid       = (count_reg != 2'd0);
    assign ray.origin_x    = $signed(q_head.origin[0]);
    assign ray.origin_y    = $signed(q_head.origin[1]);
    assign ray.origin_z    = $signed(q_head.origin[2]);
    assign ray.dir_x       = $signed(q_head.dir[0]);
    assign ray.dir_y       = $signed(q_head.dir[1]);
    assign ray.dir_z       = $signed(q_head.dir[2]);
    assign ray.zero_length = q_head.zero;

endmodule
